### design/accel_roll_angle_smoother_defines.svh
// assertion macros for the roll angle smoother
`ifndef ACCEL_ROLL_ANGLE_SMOOTHER_DEFINES_SVH
`define ACCEL_ROLL_ANGLE_SMOOTHER_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define ARSM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// condition that must never be seen out of reset
`define ARSM_NEVER(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define ARSM_ASSERT(name, prop, msg)
`define ARSM_NEVER(name, cond, msg)
`endif

`endif

### design/arsm_pkg.sv
package arsm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int STEP_W       = $clog2(TABLE_LEN);
    // corrected samples carry one extra bit, the cordic x and y three more for gain
    localparam int XY_W         = SAMPLE_BITS + 4;
    localparam int ANG_W        = 24;
    localparam int ROLL_W       = 16;
    localparam int ALPHA_W      = 17;
    localparam int AVG_W        = 32;
    localparam int CLAMP_W      = 36;
    localparam int CFG_IDX_W    = 2;
    localparam int ROLL_LIMIT   = 23040;
    localparam int ALPHA_ONE    = 65536;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd2;

    // how the roll of an item is found
    typedef enum logic [1:0] {
        CLS_CORDIC,
        CLS_ZERO,
        CLS_POS,
        CLS_NEG
    } roll_cls_t;

    // payload handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] ang;
        roll_cls_t               cls;
    } cordic_t;

    // atan(2^-i) in degrees, scaled by 2^16
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = 24'sd2949120;
            5'd1:    r = 24'sd1740967;
            5'd2:    r = 24'sd919879;
            5'd3:    r = 24'sd466945;
            5'd4:    r = 24'sd234379;
            5'd5:    r = 24'sd117304;
            5'd6:    r = 24'sd58666;
            5'd7:    r = 24'sd29335;
            5'd8:    r = 24'sd14668;
            5'd9:    r = 24'sd7334;
            5'd10:   r = 24'sd3667;
            5'd11:   r = 24'sd1833;
            5'd12:   r = 24'sd917;
            5'd13:   r = 24'sd458;
            5'd14:   r = 24'sd229;
            5'd15:   r = 24'sd115;
            5'd16:   r = 24'sd57;
            5'd17:   r = 24'sd29;
            5'd18:   r = 24'sd14;
            5'd19:   r = 24'sd7;
            5'd20:   r = 24'sd4;
            5'd21:   r = 24'sd2;
            5'd22:   r = 24'sd1;
            default: r = 24'sd0;
        endcase
        return r;
    endfunction

    // limit an angle to plus or minus ninety degrees in q8.8
    function automatic logic signed [ROLL_W-1:0] clamp_roll(input logic signed [CLAMP_W-1:0] v);
        logic signed [ROLL_W-1:0] r;
        if (v > CLAMP_W'(ROLL_LIMIT)) begin
            r = ROLL_W'(ROLL_LIMIT);
        end else if (v < -CLAMP_W'(ROLL_LIMIT)) begin
            r = -ROLL_W'(ROLL_LIMIT);
        end else begin
            r = v[ROLL_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/accel_roll_angle_smoother.sv
// channel   direction  handshake                   payload
// s_        in         s_tvalid / s_tready         s_tdata: accel_y, accel_z
// m_        out        m_tvalid / m_tready         m_tdata: roll_raw, roll_smoothed
// cfg_      in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// an item is loaded into the first of 16 cordic cells at the edge that accepts it,
// then passes the roll, multiply, blend and output registers in that order.
// the next item is taken once the result reaches the output register, so the
// block takes no new item while the last one is still in the cells or stages.
// a result that is not taken holds the following item in the blend stage.
// reset (aresetn low, synchronous) clears offsets to 0, weight to 65536 and the
// average to 0; config writes are always taken.
`include "accel_roll_angle_smoother_defines.svh"

module accel_roll_angle_smoother
    import arsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,    // accel_y [15:0], accel_z [31:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // roll_raw [15:0], roll_smoothed [31:16]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ALPHA_W-1:0]    cfg_data
);

    logic signed [SAMPLE_BITS-1:0] offset_y_reg;
    logic signed [SAMPLE_BITS-1:0] offset_z_reg;
    logic [ALPHA_W-1:0]            weight_reg;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          s_accept;
    logic                          out_load;
    logic signed [SAMPLE_BITS:0]   yc;
    logic signed [SAMPLE_BITS:0]   zc;
    cordic_t                       head_data;
    logic [CORDIC_STEPS:0]         cell_valid;
    cordic_t                       cell_data [CORDIC_STEPS+1];

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            weight_reg   <= ALPHA_W'(ALPHA_ONE);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_OFFSET_Y: offset_y_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_OFFSET_Z: offset_z_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_WEIGHT:   weight_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // one item in the cells at a time
    assign busy_next = s_accept ? 1'b1 : (out_load ? 1'b0 : busy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // offset correction and special-case sorting
    assign yc = (SAMPLE_BITS+1)'($signed(s_tdata[15:0])) - (SAMPLE_BITS+1)'(offset_y_reg);
    assign zc = (SAMPLE_BITS+1)'($signed(s_tdata[31:16])) - (SAMPLE_BITS+1)'(offset_z_reg);

    always_comb begin
        head_data.x   = XY_W'(zc);
        head_data.y   = XY_W'(yc);
        head_data.ang = '0;
        if (yc == 0 && zc == 0) begin
            head_data.cls = CLS_ZERO;
        end else if (zc <= 0) begin
            head_data.cls = (yc >= 0) ? CLS_POS : CLS_NEG;
        end else begin
            head_data.cls = CLS_CORDIC;
        end
    end

    assign cell_valid[0] = s_accept;
    assign cell_data[0]  = head_data;

    // row of cordic cells
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        arsm_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step_idx  (STEP_W'(k)),
            .in_valid  (cell_valid[k]),
            .in_data   (cell_data[k]),
            .out_valid (cell_valid[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    // roll, average update and output register
    arsm_ema u_ema (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cell_valid[CORDIC_STEPS]),
        .in_data  (cell_data[CORDIC_STEPS]),
        .weight   (weight_reg),
        .out_load (out_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `ARSM_ASSERT(a_accept_sets_busy, s_accept |=> busy_reg, "accepted item did not mark busy")
    `ARSM_ASSERT(a_single_in_row, $onehot0(cell_valid), "more than one item in the cell row")
    `ARSM_NEVER(a_raw_range,
        m_tvalid && ($signed(m_tdata[15:0]) > ROLL_LIMIT || $signed(m_tdata[15:0]) < -ROLL_LIMIT),
        "raw roll out of range")
    `ARSM_NEVER(a_sm_range,
        m_tvalid && ($signed(m_tdata[31:16]) > ROLL_LIMIT || $signed(m_tdata[31:16]) < -ROLL_LIMIT),
        "smoothed roll out of range")

endmodule

### design/arsm_cordic_cell.sv
module arsm_cordic_cell
    import arsm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [STEP_W-1:0]   step_idx,
    input  logic                in_valid,
    input  cordic_t             in_data,
    output logic                out_valid,
    output cordic_t             out_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    // one vectoring rotation toward the x axis
    always_comb begin
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = in_data.x >>> step_idx;
        ys = in_data.y >>> step_idx;
        data_next = in_data;
        if (in_data.y >= 0) begin
            data_next.x   = in_data.x + ys;
            data_next.y   = in_data.y - xs;
            data_next.ang = in_data.ang + atan_q16(step_idx);
        end else begin
            data_next.x   = in_data.x - ys;
            data_next.y   = in_data.y + xs;
            data_next.ang = in_data.ang - atan_q16(step_idx);
        end
    end

    // valid marker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/arsm_ema.sv
module arsm_ema
    import arsm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  cordic_t             in_data,
    input  logic [ALPHA_W-1:0]  weight,
    output logic                out_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);

    localparam int P1_W  = ALPHA_W + 1 + ROLL_W;
    localparam int P2_W  = ALPHA_W + 1 + AVG_W;
    localparam int SUM_W = P2_W + 2;

    logic                     r_valid_reg;
    logic signed [ROLL_W-1:0] r_roll_reg;
    logic signed [ROLL_W-1:0] r_roll_next;
    logic                     a_valid_reg;
    logic signed [ROLL_W-1:0] a_roll_reg;
    logic signed [P1_W-1:0]   a_p1_reg;
    logic signed [P2_W-1:0]   a_p2_reg;
    logic                     b_valid_reg;
    logic                     b_valid_next;
    logic signed [ROLL_W-1:0] b_roll_reg;
    logic signed [AVG_W-1:0]  average_reg;
    logic signed [AVG_W-1:0]  average_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [ROLL_W-1:0] out_raw_reg;
    logic signed [ROLL_W-1:0] out_sm_reg;
    logic signed [ROLL_W-1:0] sm_next;
    logic [ALPHA_W-1:0]       alpha;
    logic [ALPHA_W-1:0]       beta;

    // final roll from the rotated angle or the special cases
    always_comb begin
        logic signed [ANG_W:0] rounded;
        rounded = (ANG_W+1)'(in_data.ang) + (ANG_W+1)'(128);
        unique case (in_data.cls)
            CLS_CORDIC: r_roll_next = clamp_roll(CLAMP_W'(rounded >>> 8));
            CLS_ZERO:   r_roll_next = '0;
            CLS_POS:    r_roll_next = ROLL_W'(ROLL_LIMIT);
            CLS_NEG:    r_roll_next = -ROLL_W'(ROLL_LIMIT);
            default:    r_roll_next = '0;
        endcase
    end

    // saturated weight and its complement
    assign alpha = (weight > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : weight;
    assign beta  = ALPHA_W'(ALPHA_ONE) - alpha;

    // blend of new roll and old average, rounded back to 2^-24 degree
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] q;
        s = (SUM_W'(a_p1_reg) <<< 16) + SUM_W'(a_p2_reg) + SUM_W'(32768);
        q = s >>> 16;
        if (q > SUM_W'(32'sh7fffffff)) begin
            average_next = 32'sh7fffffff;
        end else if (q < -SUM_W'(33'sh080000000)) begin
            average_next = 32'sh80000000;
        end else begin
            average_next = q[AVG_W-1:0];
        end
    end

    // smoothed roll in q8.8 from the average
    always_comb begin
        logic signed [AVG_W:0] t;
        t = (AVG_W+1)'(average_reg) + (AVG_W+1)'(32768);
        sm_next = clamp_roll(CLAMP_W'(t >>> 16));
    end

    // hand the waiting item to the output register when it is free
    assign out_load       = b_valid_reg && (!out_valid_reg || m_tready);
    assign b_valid_next   = a_valid_reg ? 1'b1 : (out_load ? 1'b0 : b_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0 : out_valid_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            average_reg   <= '0;
        end else begin
            r_valid_reg   <= in_valid;
            a_valid_reg   <= r_valid_reg;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (a_valid_reg) begin
                average_reg <= average_next;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        r_roll_reg <= r_roll_next;
        a_roll_reg <= r_roll_reg;
        a_p1_reg   <= $signed({1'b0, alpha}) * r_roll_reg;
        a_p2_reg   <= $signed({1'b0, beta}) * average_reg;
        if (a_valid_reg) begin
            b_roll_reg <= a_roll_reg;
        end
        if (out_load) begin
            out_raw_reg <= b_roll_reg;
            out_sm_reg  <= sm_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sm_reg, out_raw_reg};

endmodule

### tb/sv/accel_roll_angle_smoother_checker.sv
`timescale 1ns / 100ps

module accel_roll_angle_smoother_checker
    import arsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,    // accel_y [15:0], accel_z [31:16]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,    // roll_raw [15:0], roll_smoothed [31:16]
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   result_count
);

    typedef struct {
        logic signed [ROLL_W-1:0] raw;
        logic signed [ROLL_W-1:0] smooth;
    } roll_pair_t;

    // atan(2^-i) in degrees, scaled by 2^16
    longint atan_step_q16 [0:TABLE_LEN-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic [15:0]         offset_y_q;
    logic [15:0]         offset_z_q;
    logic [ALPHA_W-1:0]  weight_q;
    logic signed [31:0]  average_q;
    roll_pair_t          expected_rolls [$];

    function automatic longint limit_roll(input longint v);
        if (v > longint'(ROLL_LIMIT)) begin
            return longint'(ROLL_LIMIT);
        end
        if (v < -longint'(ROLL_LIMIT)) begin
            return -longint'(ROLL_LIMIT);
        end
        return v;
    endfunction

    // vectoring cordic on the corrected pair, angle rounded to q8.8
    function automatic longint tilt_q88(input longint yc, input longint zc);
        longint xa;
        longint ya;
        longint acc;
        longint xs;
        longint ys;
        int     i;
        if (yc == 0 && zc == 0) begin
            return 0;
        end
        // beyond +/-90 degrees or straight up/down
        if (zc <= 0) begin
            return (yc >= 0) ? longint'(ROLL_LIMIT) : -longint'(ROLL_LIMIT);
        end
        xa  = zc;
        ya  = yc;
        acc = 0;
        for (i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya >= 0) begin
                xa  = xa + ys;
                ya  = ya - xs;
                acc = acc + atan_step_q16[i];
            end else begin
                xa  = xa - ys;
                ya  = ya + xs;
                acc = acc - atan_step_q16[i];
            end
        end
        return limit_roll((acc + 128) >>> 8);
    endfunction

    // roll of one sample pair plus the moving average update
    function automatic roll_pair_t predict_roll(input logic [31:0] sample);
        roll_pair_t r;
        longint     yc;
        longint     zc;
        longint     roll;
        longint     alpha;
        longint     blend;
        longint     avg;
        yc    = longint'($signed(sample[15:0])) - longint'($signed(offset_y_q));
        zc    = longint'($signed(sample[31:16])) - longint'($signed(offset_z_q));
        roll  = tilt_q88(yc, zc);
        alpha = (weight_q > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(weight_q);
        blend = alpha * roll * 65536 + (longint'(ALPHA_ONE) - alpha) * longint'(average_q);
        avg   = (blend + 32768) >>> 16;
        if (avg > 64'sd2147483647) begin
            avg = 64'sd2147483647;
        end
        if (avg < -64'sd2147483648) begin
            avg = -64'sd2147483648;
        end
        average_q = avg[31:0];
        r.raw     = roll[ROLL_W-1:0];
        r.smooth  = ROLL_W'(limit_roll((avg + 32768) >>> 16));
        return r;
    endfunction

    // follow the config channel, predict on input items, compare on results
    always @(posedge aclk) begin
        roll_pair_t exp_r;
        logic signed [ROLL_W-1:0] got_raw;
        logic signed [ROLL_W-1:0] got_smooth;
        if (!aresetn) begin
            offset_y_q   = '0;
            offset_z_q   = '0;
            weight_q     = ALPHA_W'(ALPHA_ONE);
            average_q    = '0;
            expected_rolls.delete();
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OFFSET_Y: offset_y_q = cfg_data[15:0];
                    REG_OFFSET_Z: offset_z_q = cfg_data[15:0];
                    REG_WEIGHT:   weight_q   = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                result_count++;
                got_raw    = m_tdata[15:0];
                got_smooth = m_tdata[31:16];
                if (expected_rolls.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with nothing expected: raw %0d smoothed %0d",
                                 $realtime, got_raw, got_smooth);
                    end
                end else begin
                    exp_r = expected_rolls.pop_front();
                    if (got_raw !== exp_r.raw || got_smooth !== exp_r.smooth) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"%0t: roll mismatch: raw exp %0d got %0d, ",
                                      "smoothed exp %0d got %0d"},
                                     $realtime, exp_r.raw, got_raw, exp_r.smooth, got_smooth);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_rolls.push_back(predict_roll(s_tdata));
            end
        end
        pending = expected_rolls.size();
    end

endmodule

### tb/sv/accel_roll_angle_smoother_tb.sv
`timescale 1ns / 100ps

module accel_roll_angle_smoother_tb;
    import arsm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;    // accel_y [15:0], accel_z [31:16]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;    // roll_raw [15:0], roll_smoothed [31:16]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ALPHA_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int result_count;

    bit          calm = 1'b0;
    int          hold_request = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          settings_used = 1;
    logic [15:0] cur_off_y = '0;
    logic [15:0] cur_off_z = '0;

    accel_roll_angle_smoother dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    accel_roll_angle_smoother_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, calm stretches, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 21);
            end
        end
    end

    // offer one sample pair, with a random gap ahead of it
    task automatic send_sample(input logic [15:0] y, input logic [15:0] z);
        while (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    // stop offering and wait for every outstanding roll
    task automatic drain_rolls();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    // all registers plus a write to the unused index, block idle
    task automatic set_config(input logic [15:0] oy, input logic [15:0] oz,
                              input logic [ALPHA_W-1:0] weight);
        write_reg(REG_OFFSET_Y, {1'($urandom), oy});
        write_reg(REG_OFFSET_Z, {1'($urandom), oz});
        write_reg(REG_WEIGHT, weight);
        write_reg(REG_SPARE, ALPHA_W'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cur_off_y = oy;
        cur_off_z = oz;
        settings_used++;
    endtask

    // sample near the offset often, so corrected zero shows up
    function automatic logic [15:0] pick_y(input logic [15:0] offs);
        case ($urandom_range(9))
            0:       return offs;
            1, 2:    return offs + 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly above the z offset so the cordic path gets exercised
    function automatic logic [15:0] pick_z(input logic [15:0] offs);
        int lo;
        lo = int'($signed(offs)) + 1;
        case ($urandom_range(9))
            0:       return offs;
            1:       return offs + 16'($urandom_range(16)) - 16'd8;
            2, 3:    return 16'($urandom);
            default: begin
                if (lo > 32767) begin
                    return 16'($urandom);
                end
                return 16'(lo + int'($urandom_range(32767 - lo)));
            end
        endcase
    endfunction

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_sample(pick_y(cur_off_y), pick_z(cur_off_z));
        end
    endtask

    // stimulus and verdict
    initial begin
        int n;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_OFFSET_Y;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero pair, axis cases, beyond ninety degrees, extremes
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd100, -16'sd100);
        send_sample(16'sd0, -16'sd1);
        send_sample(-16'sd1, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, 16'sd1);
        send_sample(-16'sd32768, 16'sd1);
        send_sample(16'sd1, 16'sd32767);
        send_sample(-16'sd1, 16'sd32767);
        send_sample(16'h5555, 16'h2aaa);
        send_sample(16'haaaa, 16'h5555);
        drain_rolls();

        // offset extremes, weight zero holds the average
        set_config(16'h8000, 16'h7fff, '0);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_random(150);
        drain_rolls();

        // opposite extremes, smallest nonzero weight
        set_config(16'h7fff, 16'h8000, ALPHA_W'(1));
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, 16'sd32767);
        send_random(200);
        drain_rolls();

        // a stretch with no idling on either side
        set_config('0, '0, ALPHA_W'(65535));
        calm = 1'b1;
        send_random(300);
        drain_rolls();
        calm = 1'b0;

        // weight above one saturates; the output side holds off for a long while
        set_config(16'($urandom), 16'($urandom), '1);
        hold_request = HOLD_CYCLES;
        send_random(300);
        drain_rolls();

        // small offsets, random weight within range
        set_config(16'($urandom_range(64)) - 16'd32, 16'($urandom_range(64)) - 16'd32,
                   ALPHA_W'($urandom_range(ALPHA_ONE)));
        send_random(300);
        drain_rolls();

        // any register value; the input side pauses until all rolls are back
        set_config(16'($urandom), 16'($urandom), ALPHA_W'($urandom));
        for (n = 0; n < 6; n++) begin
            send_random(50);
            drain_rolls();
        end

        // back to the reset settings
        set_config('0, '0, ALPHA_W'(ALPHA_ONE));
        send_random(250);
        drain_rolls();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d sample pairs and %0d rolls over %0d register settings,",
                 items_sent, result_count, settings_used);
        $display("with offset and weight extremes, axis cases and a long output stall.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
